// ===== rtl/ukrt_pkg.sv =====
// Package with the shared types, constants and mode codes of the record table.
`default_nettype none
package ukrt_pkg;
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int VAL_W       = 16;
    localparam int REC_W       = 32 + 3 * VAL_W;

    localparam logic [2:0] MODE_ADD    = 3'd0;
    localparam logic [2:0] MODE_REMOVE = 3'd1;
    localparam logic [2:0] MODE_SEARCH = 3'd2;
    localparam logic [2:0] MODE_SORT_A = 3'd3;
    localparam logic [2:0] MODE_SORT_D = 3'd4;
    localparam logic [2:0] MODE_QUERY  = 3'd5;
    localparam logic [2:0] MODE_READ   = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_NOTFD = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [2:0]        mode;
        logic signed [31:0] key_id;
        logic [5:0]        position;
        logic [15:0]       delay_value;
        logic [15:0]       power_value;
        logic [15:0]       price_value;
    } in_word_t;

    typedef struct packed {
        logic [1:0]        status;
        logic              found;
        logic signed [31:0] result_id;
        logic [15:0]       out_delay;
        logic [15:0]       out_power;
        logic [15:0]       out_price;
        logic [6:0]        entry_total;
        logic              table_empty;
    } out_word_t;

    // Classified command handed from the front part to the back part.
    typedef struct packed {
        logic [2:0]          mode;
        logic [31:0]         key_id;
        logic [IDX_W-1:0]    position;
        logic                pos_ok;
        logic [VAL_W-1:0]    dv;
        logic [VAL_W-1:0]    pv;
        logic [VAL_W-1:0]    cv;
    } cmd_t;

    typedef struct packed {
        logic [31:0]      id;
        logic [VAL_W-1:0] dly;
        logic [VAL_W-1:0] pwr;
        logic [VAL_W-1:0] prc;
    } rec_t;
endpackage
`default_nettype wire

// ===== rtl/ukrt_ram.sv =====
// Generic single-port RAM with registered read data.
`default_nettype none
module ukrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write at the address; the registered read returns the old contents.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

// ===== rtl/ukrt_front.sv =====
// Front part: accepts words, classifies them and holds them in a two-entry queue.
`default_nettype none
module ukrt_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire ukrt_pkg::in_word_t in_word,
    output logic                   cmd_valid,
    input  wire logic              cmd_ready,
    output ukrt_pkg::cmd_t         cmd
);
    import ukrt_pkg::*;

    cmd_t       q_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       rd_reg, wr_reg;
    cmd_t       c;
    logic       push, pop;

    // Classify: narrow the fields and flag positions past the table.
    always_comb
    begin
        c.mode     = in_word.mode;
        c.key_id   = in_word.key_id;
        c.position = IDX_W'(in_word.position);
        c.pos_ok   = (32'(in_word.position) < TABLE_DEPTH);
        c.dv       = VAL_W'(in_word.delay_value);
        c.pv       = VAL_W'(in_word.power_value);
        c.cv       = VAL_W'(in_word.price_value);
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_reg <= !wr_reg;
            end
            if (pop)
            begin
                rd_reg <= !rd_reg;
            end
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= c;
        end
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue count out of range");
    a_full_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2 && !pop) |=> cnt_reg == 2'd2)
        else $error("full queue lost an entry");
    a_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> (rd_reg == wr_reg))
        else $error("empty queue with unequal pointers");
endmodule
`default_nettype wire

// ===== rtl/ukrt_back.sv =====
// Back part: sequencer that runs each command over the record memory.
`default_nettype none
module ukrt_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cmd_valid,
    output logic                    cmd_ready,
    input  wire ukrt_pkg::cmd_t     cmd,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output ukrt_pkg::out_word_t     out_word
);
    import ukrt_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SCAN  = 4'd1;
    localparam logic [3:0] S_SCANW = 4'd2;
    localparam logic [3:0] S_SHRD  = 4'd3;
    localparam logic [3:0] S_SHRW  = 4'd4;
    localparam logic [3:0] S_SHWR  = 4'd5;
    localparam logic [3:0] S_SRA   = 4'd6;
    localparam logic [3:0] S_SRB   = 4'd7;
    localparam logic [3:0] S_SRC   = 4'd8;
    localparam logic [3:0] S_SRW1  = 4'd9;
    localparam logic [3:0] S_SRW2  = 4'd10;
    localparam logic [3:0] S_RDW   = 4'd11;
    localparam logic [3:0] S_RDD   = 4'd12;
    localparam logic [3:0] S_DONE  = 4'd13;
    localparam logic [3:0] S_ADDW  = 4'd14;

    logic [3:0]       st_reg;
    cmd_t             cmd_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] i_reg;
    logic [CNT_W-1:0] pass_reg;
    logic [IDX_W-1:0] addr;
    logic             we;
    rec_t             wdata, rdata, a_reg;
    logic             ov_reg;
    out_word_t        ow_reg;
    logic [1:0]       st_code;
    logic             hit;
    logic             sw;

    ukrt_ram #(.WIDTH(REC_W), .DEPTH(TABLE_DEPTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata (wdata),
        .rdata (rdata)
    );

    assign cmd_ready = (st_reg == S_IDLE) && !ov_reg;
    assign out_valid = ov_reg;
    assign out_word  = ow_reg;

    // Match test and sort swap compare on the record read back from memory.
    always_comb
    begin
        if (cmd_reg.mode == MODE_QUERY)
        begin
            hit = (rdata.dly <= cmd_reg.dv) && (rdata.pwr <= cmd_reg.pv)
                && (rdata.prc <= cmd_reg.cv);
        end
        else
        begin
            hit = (rdata.id == cmd_reg.key_id);
        end
        if (cmd_reg.mode == MODE_SORT_A)
        begin
            sw = $signed(a_reg.id) > $signed(rdata.id);
        end
        else
        begin
            sw = $signed(rdata.id) > $signed(a_reg.id);
        end
    end

    // Memory address and write selection.
    always_comb
    begin
        addr  = IDX_W'(i_reg);
        we    = 1'b0;
        wdata = a_reg;
        unique case (st_reg)
            S_ADDW:
            begin
                we    = 1'b1;
                wdata = '{id: cmd_reg.key_id, dly: cmd_reg.dv, pwr: cmd_reg.pv,
                          prc: cmd_reg.cv};
            end
            S_SHRW:
            begin
                addr = IDX_W'(i_reg - CNT_W'(1));
                we   = 1'b1;
                wdata = rdata;
            end
            S_SRB:
            begin
                addr = IDX_W'(i_reg + CNT_W'(1));
            end
            S_SRC:
            begin
                // Keep entry i+1 on the read port for the swap write.
                addr = IDX_W'(i_reg + CNT_W'(1));
            end
            S_SRW1:
            begin
                we    = 1'b1;
                wdata = rdata;
            end
            S_SRW2:
            begin
                addr  = IDX_W'(i_reg + CNT_W'(1));
                we    = 1'b1;
                wdata = a_reg;
            end
            S_RDW:
            begin
                addr = cmd_reg.position;
            end
            default:
            begin
                addr = IDX_W'(i_reg);
            end
        endcase
    end

    assign st_code = ow_reg.status;

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg    <= S_IDLE;
            count_reg <= '0;
            ov_reg    <= 1'b0;
            i_reg     <= '0;
            pass_reg  <= '0;
            cmd_reg   <= '0;
            a_reg     <= '0;
            ow_reg    <= '0;
        end
        else
        begin
            if (ov_reg && out_ready)
            begin
                ov_reg <= 1'b0;
            end
            unique case (st_reg)
                S_IDLE:
                begin
                    if (cmd_valid && cmd_ready)
                    begin
                        cmd_reg  <= cmd;
                        i_reg    <= '0;
                        pass_reg <= '0;
                        ow_reg   <= '0;
                        priority case (cmd.mode)
                            MODE_ADD, MODE_REMOVE, MODE_SEARCH, MODE_QUERY:
                            begin
                                st_reg <= S_SCAN;
                            end
                            MODE_SORT_A, MODE_SORT_D:
                            begin
                                st_reg <= S_SRA;
                            end
                            MODE_READ:
                            begin
                                st_reg <= S_RDW;
                            end
                            default:
                            begin
                                st_reg <= S_DONE;
                            end
                        endcase
                    end
                end
                S_SCAN:
                begin
                    if (i_reg >= count_reg)
                    begin
                        // No hit in the whole table.
                        priority case (cmd_reg.mode)
                            MODE_ADD:
                            begin
                                if (count_reg >= CNT_W'(TABLE_DEPTH))
                                begin
                                    ow_reg.status <= ST_FULL;
                                    st_reg        <= S_DONE;
                                end
                                else
                                begin
                                    st_reg <= S_ADDW;
                                end
                            end
                            default:
                            begin
                                ow_reg.status <= ST_NOTFD;
                                st_reg        <= S_DONE;
                            end
                        endcase
                    end
                    else
                    begin
                        st_reg <= S_SCANW;
                    end
                end
                S_SCANW:
                begin
                    if (hit)
                    begin
                        ow_reg.found <= 1'b1;
                        priority case (cmd_reg.mode)
                            MODE_ADD:
                            begin
                                ow_reg.status <= ST_DUP;
                                st_reg        <= S_DONE;
                            end
                            MODE_REMOVE:
                            begin
                                i_reg  <= i_reg + CNT_W'(1);
                                st_reg <= S_SHRD;
                            end
                            MODE_QUERY:
                            begin
                                ow_reg.result_id <= rdata.id;
                                ow_reg.out_delay <= rdata.dly;
                                ow_reg.out_power <= rdata.pwr;
                                ow_reg.out_price <= rdata.prc;
                                st_reg           <= S_DONE;
                            end
                            default:
                            begin
                                st_reg <= S_DONE;
                            end
                        endcase
                    end
                    else
                    begin
                        i_reg  <= i_reg + CNT_W'(1);
                        st_reg <= S_SCAN;
                    end
                end
                S_ADDW:
                begin
                    count_reg <= count_reg + CNT_W'(1);
                    st_reg    <= S_DONE;
                end
                S_SHRD:
                begin
                    // Read entry i, then write it to i-1.
                    if (i_reg >= count_reg)
                    begin
                        count_reg <= count_reg - CNT_W'(1);
                        st_reg    <= S_DONE;
                    end
                    else
                    begin
                        st_reg <= S_SHWR;
                    end
                end
                S_SHWR:
                begin
                    st_reg <= S_SHRW;
                end
                S_SHRW:
                begin
                    i_reg  <= i_reg + CNT_W'(1);
                    st_reg <= S_SHRD;
                end
                S_SRA:
                begin
                    // Start of one compare step at position i.
                    if (pass_reg + CNT_W'(1) >= count_reg)
                    begin
                        st_reg <= S_DONE;
                    end
                    else if (i_reg + CNT_W'(1) >= count_reg)
                    begin
                        i_reg    <= '0;
                        pass_reg <= pass_reg + CNT_W'(1);
                    end
                    else
                    begin
                        st_reg <= S_SRB;
                    end
                end
                S_SRB:
                begin
                    a_reg  <= rdata;
                    st_reg <= S_SRC;
                end
                S_SRC:
                begin
                    if (sw)
                    begin
                        st_reg <= S_SRW1;
                    end
                    else
                    begin
                        i_reg  <= i_reg + CNT_W'(1);
                        st_reg <= S_SRA;
                    end
                end
                S_SRW1:
                begin
                    st_reg <= S_SRW2;
                end
                S_SRW2:
                begin
                    i_reg  <= i_reg + CNT_W'(1);
                    st_reg <= S_SRA;
                end
                S_RDW:
                begin
                    st_reg <= S_RDD;
                end
                S_RDD:
                begin
                    if (cmd_reg.pos_ok && (CNT_W'(cmd_reg.position) < count_reg))
                    begin
                        ow_reg.found     <= 1'b1;
                        ow_reg.result_id <= rdata.id;
                        ow_reg.out_delay <= rdata.dly;
                        ow_reg.out_power <= rdata.pwr;
                        ow_reg.out_price <= rdata.prc;
                    end
                    else
                    begin
                        ow_reg.status <= ST_NOTFD;
                    end
                    st_reg <= S_DONE;
                end
                S_DONE:
                begin
                    ow_reg.entry_total <= 7'(count_reg);
                    ow_reg.table_empty <= (count_reg == '0);
                    ov_reg             <= 1'b1;
                    st_reg             <= S_IDLE;
                end
                default:
                begin
                    st_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("record count above depth");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> !cmd_ready)
        else $error("took a command with a result pending");
    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && st_code == ST_FULL) |-> count_reg == CNT_W'(TABLE_DEPTH))
        else $error("full reported below depth");
endmodule
`default_nettype wire

// ===== rtl/unique_key_record_table.sv =====
// Top level of the unique-key record table.
// Operation: add/search/query/remove scan the entries in order; remove then shifts the
// later entries down one place; sort is a bubble sort with (n-1)^2 compares.
// One word is in work at a time in the sequencer; a two-entry queue takes words ahead.
// Reset: rst_n clears the count and the queue; record memory is not cleared.
`default_nettype none
module unique_key_record_table (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire ukrt_pkg::in_word_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output ukrt_pkg::out_word_t      out_data
);
    import ukrt_pkg::*;

    cmd_t cmd;
    logic cmd_valid, cmd_ready;

    ukrt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_word   (in_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    ukrt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_word  (out_data)
    );
endmodule
`default_nettype wire
